// ===== sv/vpd_pkg.sv =====
// vpd_pkg: shared types, codes and constants of the varint packet deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package vpd_pkg;

  localparam int MAX_VARINT_BYTES_DEF = 5;

  localparam int DATA_W  = 8;
  localparam int ID_W    = 32;
  localparam int LEN_W   = 31;
  localparam int KIND_W  = 2;
  localparam int ERR_W   = 2;
  localparam int GROUP_W = 7;

  typedef enum logic [1:0] {
    PH_SIZE,
    PH_DLEN,
    PH_ID,
    PH_PAYLOAD
  } phase_t;

  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CLOSED    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_MALFORMED = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] rx_byte;
    logic              stream_closed;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  payload_length;
    logic              compressed;
    logic [LEN_W-1:0]  uncompressed_length;
    logic [DATA_W-1:0] data_byte;
    logic              last;
    logic [ERR_W-1:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/vpd_if.sv =====
// vpd_in_if / vpd_out_if: valid-ready channels of the deframer
// depends on vpd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface vpd_in_if
  import vpd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rx_byte;
  logic              stream_closed;

  modport source (output valid, output rx_byte, output stream_closed, input ready);
  modport sink   (input valid, input rx_byte, input stream_closed, output ready);
endinterface

interface vpd_out_if
  import vpd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   frame_id;
  logic [LEN_W-1:0]  payload_length;
  logic              compressed;
  logic [LEN_W-1:0]  uncompressed_length;
  logic [DATA_W-1:0] data_byte;
  logic              last;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, output kind, output frame_id, output payload_length,
                  output compressed, output uncompressed_length, output data_byte,
                  output last, output error_code, input ready);
  modport sink   (input valid, input kind, input frame_id, input payload_length,
                  input compressed, input uncompressed_length, input data_byte,
                  input last, input error_code, output ready);
endinterface

`default_nettype wire

// ===== sv/vpd_in_stage.sv =====
// vpd_in_stage: input register holding one received request
// depends on vpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module vpd_in_stage
  import vpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [DATA_W-1:0] in_byte,
  input  wire logic              in_closed,
  output logic                   in_ready,
  input  wire logic              take,
  output in_req_t                req
);

  in_req_t held;

  // free when empty or when the held request moves on this cycle
  assign in_ready = !held.valid || take;
  assign req      = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (in_ready) begin
      held.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held.rx_byte       <= in_byte;
      held.stream_closed <= in_closed;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vpd_varint.sv =====
// vpd_varint: one byte step of the little-endian base-128 decoder
// depends on vpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module vpd_varint
  import vpd_pkg::*;
#(
  parameter int MAX_BYTES = MAX_VARINT_BYTES_DEF,
  parameter int CNT_W     = $clog2(MAX_BYTES + 1)
) (
  input  wire logic [ID_W-1:0]   acc,
  input  wire logic [CNT_W-1:0]  cnt,
  input  wire logic [DATA_W-1:0] byte_in,
  output logic      [ID_W-1:0]   value,
  output logic      [CNT_W-1:0]  cnt_next,
  output logic                   done,
  output logic                   too_long
);

  localparam int SHIFT_W = $clog2(GROUP_W * MAX_BYTES + 1);

  logic [SHIFT_W-1:0] shift;
  logic [ID_W-1:0]    group;

  assign shift = SHIFT_W'(cnt) * SHIFT_W'(GROUP_W);

  always_comb begin
    group = '0;
    // groups landing beyond the word are dropped
    if (shift < SHIFT_W'(ID_W)) begin
      group = ID_W'(byte_in[GROUP_W-1:0]) << shift;
    end
  end

  assign value    = acc | group;
  assign cnt_next = cnt + CNT_W'(1);
  assign done     = !byte_in[DATA_W-1];
  assign too_long = byte_in[DATA_W-1] && (cnt_next >= CNT_W'(MAX_BYTES));

endmodule

`default_nettype wire

// ===== sv/vpd_parser.sv =====
// vpd_parser: frame state, header and payload decisions, result register
// depends on vpd_pkg and vpd_varint
`timescale 1ns / 1ps
`default_nettype none

module vpd_parser
  import vpd_pkg::*;
#(
  parameter int MAX_BYTES = MAX_VARINT_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    compression_enable,
  input  wire in_req_t req,
  output logic         take,
  input  wire logic    res_ready,
  output logic         res_valid,
  output result_t      res
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  phase_t             phase, phase_next;
  logic [ID_W-1:0]    acc, acc_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [LEN_W-1:0]   dlen, dlen_next;
  logic               comp, comp_next;

  logic               emit;
  result_t            res_next;

  logic [ID_W-1:0]    v_value;
  logic [CNT_W-1:0]   v_cnt;
  logic               v_done, v_too_long;
  logic               out_free;
  logic [LEN_W-1:0]   rem_dec;

  vpd_varint #(.MAX_BYTES(MAX_BYTES), .CNT_W(CNT_W)) u_varint (
    .acc      (acc),
    .cnt      (cnt),
    .byte_in  (req.rx_byte),
    .value    (v_value),
    .cnt_next (v_cnt),
    .done     (v_done),
    .too_long (v_too_long)
  );

  assign out_free = !res_valid || res_ready;
  assign take     = req.valid && out_free;
  assign rem_dec  = remaining - LEN_W'(1);

  // state update and result for the held request
  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    remaining_next = remaining;
    dlen_next      = dlen;
    comp_next      = comp;
    emit           = 1'b0;
    res_next       = '0;

    if (req.stream_closed) begin
      emit                = 1'b1;
      res_next.kind       = KIND_ABORT;
      res_next.last       = 1'b1;
      res_next.error_code = ERR_CLOSED;
    end else begin
      case (phase)
        PH_SIZE: begin
          if (v_too_long) begin
            emit                = 1'b1;
            res_next.kind       = KIND_ABORT;
            res_next.last       = 1'b1;
            res_next.error_code = ERR_TOO_LONG;
          end else if (!v_done) begin
            acc_next = v_value;
            cnt_next = v_cnt;
          end else if (v_value == '0) begin
            emit                = 1'b1;
            res_next.kind       = KIND_ABORT;
            res_next.last       = 1'b1;
            res_next.error_code = ERR_CLOSED;
          end else if (v_value[ID_W-1]) begin
            emit                = 1'b1;
            res_next.kind       = KIND_ABORT;
            res_next.last       = 1'b1;
            res_next.error_code = ERR_MALFORMED;
          end else begin
            acc_next       = '0;
            cnt_next       = '0;
            remaining_next = v_value[LEN_W-1:0];
            comp_next      = 1'b0;
            dlen_next      = '0;
            phase_next     = compression_enable ? PH_DLEN : PH_ID;
          end
        end
        PH_DLEN, PH_ID: begin
          remaining_next = rem_dec;
          if (remaining == '0) begin
            emit                = 1'b1;
            res_next.kind       = KIND_ABORT;
            res_next.last       = 1'b1;
            res_next.error_code = ERR_MALFORMED;
          end else if (v_too_long) begin
            emit                = 1'b1;
            res_next.kind       = KIND_ABORT;
            res_next.last       = 1'b1;
            res_next.error_code = ERR_TOO_LONG;
          end else if (!v_done) begin
            acc_next = v_value;
            cnt_next = v_cnt;
          end else begin
            acc_next = '0;
            cnt_next = '0;
            if (phase == PH_DLEN && v_value[ID_W-1]) begin
              emit                = 1'b1;
              res_next.kind       = KIND_ABORT;
              res_next.last       = 1'b1;
              res_next.error_code = ERR_MALFORMED;
            end else if (phase == PH_DLEN && v_value == '0) begin
              phase_next = PH_ID;
            end else begin
              emit                    = 1'b1;
              res_next.kind           = KIND_HEADER;
              res_next.payload_length = rem_dec;
              res_next.last           = (rem_dec == '0);
              phase_next              = (rem_dec == '0) ? PH_SIZE : PH_PAYLOAD;
              if (phase == PH_DLEN) begin
                comp_next                    = 1'b1;
                dlen_next                    = v_value[LEN_W-1:0];
                res_next.compressed          = 1'b1;
                res_next.uncompressed_length = v_value[LEN_W-1:0];
              end else begin
                res_next.frame_id = v_value;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (remaining != '0) begin
            remaining_next = rem_dec;
          end
          emit               = 1'b1;
          res_next.kind      = KIND_PAYLOAD;
          res_next.data_byte = req.rx_byte;
          res_next.last      = (remaining_next == '0);
          if (remaining_next == '0) begin
            phase_next = PH_SIZE;
            comp_next  = 1'b0;
            dlen_next  = '0;
          end
        end
        default: begin
          phase_next = PH_SIZE;
        end
      endcase
    end

    // any abort resynchronises on a fresh size varint
    if (emit && res_next.kind == KIND_ABORT) begin
      phase_next     = PH_SIZE;
      acc_next       = '0;
      cnt_next       = '0;
      remaining_next = '0;
      dlen_next      = '0;
      comp_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SIZE;
      acc       <= '0;
      cnt       <= '0;
      remaining <= '0;
      dlen      <= '0;
      comp      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        phase     <= phase_next;
        acc       <= acc_next;
        cnt       <= cnt_next;
        remaining <= remaining_next;
        dlen      <= dlen_next;
        comp      <= comp_next;
      end
      if (out_free) begin
        res_valid <= take && emit;
      end
    end
    if (out_free) begin
      res <= res_next;
    end
  end

  a_abort_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_ABORT |-> res.last && res.error_code != ERR_NONE)
    else $error("abort without last or error code");

  a_err_only_abort: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != KIND_ABORT |-> res.error_code == ERR_NONE)
    else $error("error code outside an abort");

  a_resync: assert property (@(posedge clk) disable iff (rst)
    $past(take) && res_valid && res.kind == KIND_ABORT |-> phase == PH_SIZE && cnt == '0)
    else $error("parser not back in size phase after abort");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(MAX_BYTES))
    else $error("varint byte count beyond limit");

  a_header_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_HEADER |-> res.last == (res.payload_length == '0))
    else $error("header last flag disagrees with payload length");

endmodule

`default_nettype wire

// ===== sv/varint_packet_deframer.sv =====
// varint_packet_deframer: top level, splits a byte stream into varint framed packets
// depends on vpd_pkg, vpd_if, vpd_in_stage, vpd_varint and vpd_parser
// a request goes from the input register through the parser step into the result register
// throughput: one request per cycle unless the output stalls; parser step between the registers
// a result waiting at the output still lets the input register take one more request
// reset (rst, synchronous, active high): size phase, empty registers, compression off
`timescale 1ns / 1ps
`default_nettype none

module varint_packet_deframer
  import vpd_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  // configuration: compression enable register
  input  wire logic cfg_write,
  input  wire logic cfg_data,
  // received stream in, frame results out
  vpd_in_if.sink    in_chan,
  vpd_out_if.source out_chan
);

  // compression register, sampled when a size varint completes
  logic    compression_enable;

  in_req_t req;
  logic    take;
  logic    res_valid;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      compression_enable <= 1'b0;
    end else if (cfg_write) begin
      compression_enable <= cfg_data;
    end
  end

  // input register: holds one request so the parser never stalls the link early
  vpd_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_byte   (in_chan.rx_byte),
    .in_closed (in_chan.stream_closed),
    .in_ready  (in_chan.ready),
    .take      (take),
    .req       (req)
  );

  // parser: varint step, frame bookkeeping and the result register
  vpd_parser #(.MAX_BYTES(MAX_VARINT_BYTES)) u_parser (
    .clk                (clk),
    .rst                (rst),
    .compression_enable (compression_enable),
    .req                (req),
    .take               (take),
    .res_ready          (out_chan.ready),
    .res_valid          (res_valid),
    .res                (res)
  );

  // result register straight onto the output channel
  assign out_chan.valid               = res_valid;
  assign out_chan.kind                = res.kind;
  assign out_chan.frame_id            = res.frame_id;
  assign out_chan.payload_length      = res.payload_length;
  assign out_chan.compressed          = res.compressed;
  assign out_chan.uncompressed_length = res.uncompressed_length;
  assign out_chan.data_byte           = res.data_byte;
  assign out_chan.last                = res.last;
  assign out_chan.error_code          = res.error_code;

endmodule

`default_nettype wire

// ===== verif/varint_packet_deframer_test.sv =====
// varint_packet_deframer_test: self-checking bench for the varint packet deframer
// holds a scoreboard class with its own parser of the byte stream, plus the stimulus tasks
// depends on vpd_pkg, vpd_if and the varint_packet_deframer top level
`timescale 1ns / 1ps

module varint_packet_deframer_test;
  import vpd_pkg::*;

  // run limits: watchdog, settling, end wait, tail, report count and receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned END_WAIT_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam logic [31:0] LEN_MAX        = 32'h7FFF_FFFF;

  typedef logic [DATA_W-1:0] byte_q_t[$];

  // outcome of adding one byte to a varint
  typedef enum int {
    GROUP_MORE,
    GROUP_DONE,
    GROUP_TOO_LONG
  } group_step_t;

  // scoreboard: parses the stream as the block should and queues the frame results due
  class deframe_scoreboard;
    result_t     due_results[$];
    logic        compression_on;
    phase_t      ph;
    logic [31:0] accum;
    int unsigned group_count;
    logic [31:0] remaining;
    logic [31:0] data_len;
    logic        frame_comp;
    int unsigned mismatches;
    int unsigned requests;
    int unsigned headers;
    int unsigned payload_bytes;
    int unsigned aborts;

    function new();
      compression_on = 1'b0;
      mismatches = 0;
      requests = 0;
      headers = 0;
      payload_bytes = 0;
      aborts = 0;
      restart();
    endfunction

    // back to the size varint with nothing collected
    function void restart();
      ph = PH_SIZE;
      accum = '0;
      group_count = 0;
      remaining = '0;
      data_len = '0;
      frame_comp = 1'b0;
    endfunction

    function int unsigned due_count();
      return due_results.size();
    endfunction

    function string describe(result_t r);
      return $sformatf("kind=%0d id=%h plen=%0d comp=%0d ulen=%0d data=%h last=%0d err=%0d",
                       r.kind, r.frame_id, r.payload_length, r.compressed,
                       r.uncompressed_length, r.data_byte, r.last, r.error_code);
    endfunction

    function void push_abort(logic [ERR_W-1:0] code);
      result_t r;
      restart();
      r = '0;
      r.kind = KIND_ABORT;
      r.last = 1'b1;
      r.error_code = code;
      due_results.push_back(r);
    endfunction

    function void push_header(logic [31:0] id);
      result_t r;
      r = '0;
      r.kind = KIND_HEADER;
      r.frame_id = frame_comp ? '0 : id;
      r.payload_length = remaining[LEN_W-1:0];
      r.compressed = frame_comp;
      r.uncompressed_length = frame_comp ? data_len[LEN_W-1:0] : '0;
      r.last = (remaining == 0);
      ph = (remaining == 0) ? PH_SIZE : PH_PAYLOAD;
      due_results.push_back(r);
    endfunction

    // seven bits per byte, low group first; bits beyond 32 fall away
    function group_step_t add_group(logic [7:0] b, output logic [31:0] val);
      int unsigned shift;
      shift = GROUP_W * group_count;
      val = '0;
      if (shift < 32) accum = accum | (32'(b[6:0]) << shift);
      group_count++;
      if (!b[7]) begin
        val = accum;
        accum = '0;
        group_count = 0;
        return GROUP_DONE;
      end
      if (group_count >= MAX_VARINT_BYTES_DEF) return GROUP_TOO_LONG;
      return GROUP_MORE;
    endfunction

    // one accepted request moves the parser on and may owe one result
    function void note_request(logic [7:0] b, logic closed);
      logic [31:0] v;
      group_step_t step;
      result_t r;
      requests++;
      if (closed) begin
        push_abort(ERR_CLOSED);
        return;
      end
      case (ph)
        PH_SIZE: begin
          step = add_group(b, v);
          if (step == GROUP_TOO_LONG) begin
            push_abort(ERR_TOO_LONG);
          end else if (step == GROUP_DONE) begin
            if (v == 0) push_abort(ERR_CLOSED);
            else if (v > LEN_MAX) push_abort(ERR_MALFORMED);
            else begin
              remaining = v;
              frame_comp = 1'b0;
              data_len = '0;
              ph = compression_on ? PH_DLEN : PH_ID;
            end
          end
        end
        PH_DLEN, PH_ID: begin
          if (remaining == 0) begin
            push_abort(ERR_MALFORMED);
          end else begin
            remaining--;
            step = add_group(b, v);
            if (step == GROUP_TOO_LONG) begin
              push_abort(ERR_TOO_LONG);
            end else if (step == GROUP_DONE) begin
              if (ph == PH_ID) push_header(v);
              else if (v > LEN_MAX) push_abort(ERR_MALFORMED);
              else if (v != 0) begin
                frame_comp = 1'b1;
                data_len = v;
                push_header('0);
              end else ph = PH_ID;
            end
          end
        end
        default: begin
          if (remaining != 0) remaining--;
          r = '0;
          r.kind = KIND_PAYLOAD;
          r.data_byte = b;
          r.last = (remaining == 0);
          due_results.push_back(r);
          if (remaining == 0) restart();
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("unexpected result: %s", describe(got));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.frame_id !== want.frame_id ||
          got.payload_length !== want.payload_length || got.compressed !== want.compressed ||
          got.uncompressed_length !== want.uncompressed_length ||
          got.data_byte !== want.data_byte || got.last !== want.last ||
          got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected %s, got %s", describe(want), describe(got));
      end
      case (want.kind)
        KIND_HEADER:  headers++;
        KIND_PAYLOAD: payload_bytes++;
        default:      aborts++;
      endcase
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  vpd_in_if  in_chan ();
  vpd_out_if out_chan ();

  varint_packet_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  deframe_scoreboard sb;

  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_left;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned waited;
  logic        took_any;
  result_t     seen;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random back-pressure, or a long hold-off counted down here
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // monitor: both handshakes sampled at the edge, plus the watchdog on silent cycles
  always @(posedge clk) begin
    if (!rst) begin
      took_any = 1'b0;
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(in_chan.rx_byte, in_chan.stream_closed);
        took_any = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        seen.kind = out_chan.kind;
        seen.frame_id = out_chan.frame_id;
        seen.payload_length = out_chan.payload_length;
        seen.compressed = out_chan.compressed;
        seen.uncompressed_length = out_chan.uncompressed_length;
        seen.data_byte = out_chan.data_byte;
        seen.last = out_chan.last;
        seen.error_code = out_chan.error_code;
        sb.check_result(seen);
        took_any = 1'b1;
      end
      quiet_cycles = took_any ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // offer one request, with a random gap first, and hold it until taken
  task automatic push_req(input logic [7:0] b, input logic closed);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.rx_byte <= b;
    in_chan.stream_closed <= closed;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) push_req(q[i], 1'b0);
  endtask

  // sender stops until every owed result is out, then lets the pipeline settle
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register written only with the block idle
  task automatic set_compression(input logic on);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= on;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.compression_on = on;
  endtask

  // mostly minimal encodings, now and then padded with empty groups
  function automatic int unsigned pad_groups();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  function automatic void append_varint(ref byte_q_t q, input logic [31:0] v,
                                        input int unsigned extra);
    int unsigned n;
    int unsigned i;
    logic [31:0] rest;
    n = 1;
    rest = v >> GROUP_W;
    while (rest != 0) begin
      n++;
      rest = rest >> GROUP_W;
    end
    n = n + extra;
    if (n > MAX_VARINT_BYTES_DEF) n = MAX_VARINT_BYTES_DEF;
    for (i = 0; i < n; i++) begin
      rest = (GROUP_W * i < 32) ? (v >> (GROUP_W * i)) : 32'd0;
      q.push_back({(i + 1 < n), rest[6:0]});
    end
  endfunction

  // well-formed frame: size, optional data length, id unless compressed, payload
  function automatic void build_frame(ref byte_q_t frame);
    byte_q_t hdr;
    logic [31:0] dlen;
    logic [31:0] pid;
    int unsigned plen;
    frame.delete();
    hdr.delete();
    dlen = '0;
    if (sb.compression_on && $urandom_range(0, 1) == 1) begin
      dlen = 32'($urandom) >> $urandom_range(1, 31);
      if (dlen == 0) dlen = 32'd1;
    end
    if (sb.compression_on) append_varint(hdr, dlen, pad_groups());
    if (dlen == 0) begin
      pid = 32'($urandom) >> $urandom_range(0, 32);
      append_varint(hdr, pid, pad_groups());
    end
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    append_varint(frame, hdr.size() + plen, pad_groups());
    foreach (hdr[i]) frame.push_back(hdr[i]);
    repeat (plen) frame.push_back(8'($urandom));
  endfunction

  // broken traffic; each kind leaves the parser back at the size varint
  task automatic send_noise();
    byte_q_t q;
    int unsigned cut;
    q.delete();
    case ($urandom_range(0, 7))
      0: begin
        // frame cut short, then the link closes mid-frame
        build_frame(q);
        cut = $urandom_range(1, q.size() - 1);
        q = q[0:cut-1];
        send_bytes(q);
        push_req(8'($urandom), 1'b1);
      end
      1: begin
        // one byte of a frame garbled
        build_frame(q);
        q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
        send_bytes(q);
        push_req(8'($urandom), 1'b1);
      end
      2: begin
        // zero size
        append_varint(q, 32'd0, pad_groups());
        send_bytes(q);
      end
      3: begin
        // size varint that never ends
        repeat (MAX_VARINT_BYTES_DEF) q.push_back(8'h80 | 8'($urandom));
        send_bytes(q);
      end
      4: begin
        // size at or above 2^31
        repeat (MAX_VARINT_BYTES_DEF - 1) q.push_back(8'h80 | 8'($urandom));
        q.push_back({1'b0, 3'($urandom), 1'b1, 3'($urandom)});
        send_bytes(q);
      end
      5: begin
        // header runs past the declared size
        cut = $urandom_range(1, 3);
        q.push_back(8'(cut));
        repeat (cut) q.push_back(8'h80 | 8'($urandom));
        q.push_back(8'($urandom));
        send_bytes(q);
      end
      6: push_req(8'($urandom), 1'b1);
      default: begin
        // data length at or above 2^31, only meaningful with compression on
        if (sb.compression_on) begin
          q.push_back(8'($urandom_range(5, 30)));
          repeat (MAX_VARINT_BYTES_DEF - 1) q.push_back(8'h80 | 8'($urandom));
          q.push_back({1'b0, 3'($urandom), 1'b1, 3'($urandom)});
          send_bytes(q);
        end else begin
          push_req(8'($urandom), 1'b1);
        end
      end
    endcase
  endtask

  // mostly clean frames with random content, about one event in seven broken
  task automatic run_traffic(input int unsigned n_items);
    int unsigned start;
    byte_q_t q;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_noise();
      end else begin
        build_frame(q);
        send_bytes(q);
      end
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.rx_byte <= '0;
    in_chan.stream_closed <= 1'b0;
    tx_idle_pct = 18;
    rx_idle_pct = 57;
    hold_left = 0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, compression off
    set_compression(1'b0);
    send_bytes({8'h02, 8'h01, 8'hAA});                 // header then one payload byte
    send_bytes({8'h00});                               // zero size
    send_bytes({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});   // size varint too long
    send_bytes({8'h01, 8'h80, 8'h01});                 // id longer than the frame
    send_bytes({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h07});   // largest legal size
    push_req(8'h5A, 1'b1);                             // close mid-frame
    push_req(8'hA5, 1'b1);                             // close between frames

    // directed, compression on
    set_compression(1'b1);
    send_bytes({8'h03, 8'h05, 8'h11, 8'h22});          // compressed frame
    send_bytes({8'h02, 8'h00, 8'h07});                 // zero data length, empty payload

    // sender 18 %, receiver 57 %, opening with a long receiver hold-off
    set_compression(1'b0);
    hold_left = HOLD_OFF_CYCLES;
    run_traffic(470);

    // sender 57 %, receiver 18 %, with a full pause halfway
    set_compression(1'b1);
    tx_idle_pct = 57;
    rx_idle_pct = 18;
    run_traffic(235);
    drain();
    run_traffic(235);

    // no idling on either side, both register settings
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_compression(1'b0);
    run_traffic(230);
    set_compression(1'b1);
    run_traffic(230);

    // wind down: wait for what is owed, then watch for strays
    in_chan.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (sb.due_count() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.due_count() != 0) $display("%0d results never arrived", sb.due_count());
    $display("checked %0d requests: %0d headers, %0d payload bytes, %0d aborts",
             sb.requests, sb.headers, sb.payload_bytes, sb.aborts);
    $display("both compression settings, three idling mixes, a long hold-off and a full pause");
    if (sb.mismatches == 0 && sb.due_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
